// File: rtl/cba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator package
// Shared constants, types and helpers of the block chain allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Table geometry.
  localparam int unsigned TableLimit     = 4091;
  localparam int unsigned ReservedBlocks = 5;
  localparam int unsigned TableDepth     = TableLimit - ReservedBlocks;
  localparam int unsigned AddrW          = $clog2(TableDepth);

  localparam logic [15:0] NO_BLOCK       = 16'hFFFF;
  localparam logic [15:0] FIRST_LAST     = 16'd4;
  localparam logic [15:0] TABLE_LIMIT    = 16'(TableLimit);
  localparam logic [15:0] RSV_BLOCKS     = 16'(ReservedBlocks);
  localparam logic [15:0] LAST_BLOCK     = 16'(TableLimit - 1);
  localparam logic [11:0] CARD_RESET     = 12'd2048;

  // Command kinds.
  localparam logic [1:0] KIND_REFORMAT = 2'd0;
  localparam logic [1:0] KIND_ALLOC    = 2'd1;
  localparam logic [1:0] KIND_FREE     = 2'd2;
  localparam logic [1:0] KIND_LOOKUP   = 2'd3;

  // One access to the link memory.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [15:0]      wdata;
  } ram_req_t;

  // One finished result.
  typedef struct packed {
    logic [15:0] result_block;
    logic        ok;
    logic [15:0] free_left;
  } result_t;

  // True when a block has an entry in the table.
  function automatic logic in_table(input logic [15:0] b);
    return (b >= RSV_BLOCKS) && (b < TABLE_LIMIT);
  endfunction

  // Memory address of a block.
  function automatic logic [AddrW-1:0] blk_addr(input logic [15:0] b);
    logic [15:0] a;
    a = b - RSV_BLOCKS;
    return a[AddrW-1:0];
  endfunction

endpackage

// File: rtl/cba_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface cba_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] block_number;
  logic [11:0] block_count;

  modport source (output valid, kind, block_number, block_count, input ready);
  modport sink   (input valid, kind, block_number, block_count, output ready);
endinterface

// File: rtl/cba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface cba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_block;
  logic        ok;
  logic [15:0] free_left;

  modport source (output valid, result_block, ok, free_left, input ready);
  modport sink   (input valid, result_block, ok, free_left, output ready);
endinterface

// File: rtl/cba_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the card size register.
// ----------------------------------------------------------------------------
interface cba_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/cba_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link memory
// Single-port synchronous memory of block links, read data registered.
// ----------------------------------------------------------------------------
module cba_link_ram (
  input  logic              clk_i,
  input  cba_pkg::ram_req_t req_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem_q [cba_pkg::TableDepth];
  logic [15:0] rdata_q;

  // Write first in the array, read data registered (old data on a collision).
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator sequencer
// Runs reformat sweeps, next-fit searches, chain walks and lookups against
// the link memory, one memory access per cycle.
// ----------------------------------------------------------------------------
module cba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [11:0]         card_blocks_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [15:0]         block_number_i,
  input  logic [11:0]         block_count_i,
  output cba_pkg::ram_req_t   ram_req_o,
  input  logic [15:0]         ram_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output cba_pkg::result_t    res_o
);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_WWAIT = 4'd5;
  localparam logic [3:0] S_CLR   = 4'd6;
  localparam logic [3:0] S_CLRW  = 4'd7;
  localparam logic [3:0] S_LOOK  = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] bound_q, bound_d;
  logic [15:0] wrap_end_q, wrap_end_d;
  logic        phase_q, phase_d;
  logic        rdv_q, rdv_d;
  logic [15:0] rdidx_q, rdidx_d;
  logic        first_mode_q, first_mode_d;
  logic [15:0] first_q, first_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] head_q, head_d;
  logic [11:0] left_q, left_d;
  logic [11:0] cnt_q, cnt_d;
  logic [11:0] len_q, len_d;
  logic [15:0] free_q, free_d;
  logic [15:0] last_q, last_d;
  logic        fmt_q, fmt_d;
  logic [15:0] res_blk_q, res_blk_d;
  logic        res_ok_q, res_ok_d;

  logic [15:0] lim_raw, lim;
  logic        launch;
  logic [15:0] launch_start;
  logic        srch_done, srch_hit;
  logic [15:0] srch_blk;

  // Search limit: card size less the reserved blocks, capped at the table end.
  assign lim_raw = {4'd0, card_blocks_i} - cba_pkg::RSV_BLOCKS;
  assign lim     = (lim_raw > cba_pkg::TABLE_LIMIT) ? cba_pkg::TABLE_LIMIT : lim_raw;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    bound_d      = bound_q;
    wrap_end_d   = wrap_end_q;
    phase_d      = phase_q;
    rdv_d        = 1'b0;
    rdidx_d      = rdidx_q;
    first_mode_d = first_mode_q;
    first_d      = first_q;
    cur_d        = cur_q;
    head_d       = head_q;
    left_d       = left_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    free_d       = free_q;
    last_d       = last_q;
    fmt_d        = fmt_q;
    res_blk_d    = res_blk_q;
    res_ok_d     = res_ok_q;
    ram_req_o    = '{we: 1'b0, addr: cba_pkg::blk_addr(idx_q), wdata: 16'd0};
    launch       = 1'b0;
    launch_start = 16'd0;
    srch_done    = 1'b0;
    srch_hit     = 1'b0;
    srch_blk     = cba_pkg::NO_BLOCK;

    unique case (state_q)
      // Clear one entry per cycle.
      S_SWEEP: begin
        ram_req_o.we = 1'b1;
        idx_d = idx_q + 16'd1;
        if (idx_q == cba_pkg::LAST_BLOCK) begin
          if (fmt_q) begin
            res_blk_d = cba_pkg::NO_BLOCK;
            res_ok_d  = 1'b1;
            state_d   = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (cmd_valid_i) begin
          cnt_d = block_count_i;
          unique case (kind_i)
            cba_pkg::KIND_REFORMAT: begin
              idx_d   = cba_pkg::RSV_BLOCKS;
              fmt_d   = 1'b1;
              free_d  = {4'd0, card_blocks_i} - cba_pkg::RSV_BLOCKS;
              last_d  = cba_pkg::FIRST_LAST;
              state_d = S_SWEEP;
            end
            cba_pkg::KIND_ALLOC: begin
              left_d       = block_count_i;
              first_mode_d = 1'b1;
              launch       = 1'b1;
              launch_start = last_q + 16'd1;
            end
            cba_pkg::KIND_FREE: begin
              if (block_number_i != cba_pkg::NO_BLOCK && block_number_i != 16'd0 &&
                  !cba_pkg::in_table(block_number_i)) begin
                res_blk_d = cba_pkg::NO_BLOCK;
                res_ok_d  = 1'b0;
                state_d   = S_RESP;
              end else begin
                head_d  = block_number_i;
                cur_d   = block_number_i;
                len_d   = 12'd0;
                state_d = S_WALK;
              end
            end
            cba_pkg::KIND_LOOKUP: begin
              if (cba_pkg::in_table(block_number_i)) begin
                ram_req_o.addr = cba_pkg::blk_addr(block_number_i);
                state_d = S_LOOK;
              end else begin
                res_blk_d = cba_pkg::NO_BLOCK;
                res_ok_d  = 1'b1;
                state_d   = S_RESP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Next-fit scan: a read issued each cycle until the bound, its data checked in the cycle after.
      S_SRCH: begin
        if (rdv_q && ram_rdata_i == 16'd0) begin
          srch_done = 1'b1;
          srch_hit  = 1'b1;
          srch_blk  = rdidx_q;
        end else if (free_q == 16'd0) begin
          srch_done = 1'b1;
        end else if (idx_q < bound_q) begin
          rdv_d   = 1'b1;
          rdidx_d = idx_q;
          idx_d   = idx_q + 16'd1;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          idx_d   = cba_pkg::RSV_BLOCKS;
          bound_d = wrap_end_q;
        end else begin
          srch_done = 1'b1;
        end

        if (srch_done) begin
          if (first_mode_q) begin
            if (!srch_hit) begin
              res_blk_d = cba_pkg::NO_BLOCK;
              res_ok_d  = 1'b0;
              state_d   = S_RESP;
            end else if (left_q == 12'd0) begin
              last_d    = srch_blk;
              res_blk_d = srch_blk;
              res_ok_d  = 1'b1;
              state_d   = S_RESP;
            end else begin
              first_d = srch_blk;
              cur_d   = srch_blk;
              state_d = S_MARK;
            end
          end else begin
            // Link the current block to the one found, or end it here.
            ram_req_o = '{we: 1'b1, addr: cba_pkg::blk_addr(cur_q), wdata: srch_blk};
            if (!srch_hit) begin
              res_blk_d = cba_pkg::NO_BLOCK;
              res_ok_d  = 1'b0;
              state_d   = S_RESP;
            end else begin
              cur_d   = srch_blk;
              state_d = S_MARK;
            end
          end
        end
      end

      // Take the current block: end of chain for now.
      S_MARK: begin
        ram_req_o = '{we: 1'b1, addr: cba_pkg::blk_addr(cur_q), wdata: cba_pkg::NO_BLOCK};
        left_d = left_q - 12'd1;
        if (left_q == 12'd1) begin
          last_d    = cur_q;
          free_d    = free_q - {4'd0, cnt_q};
          res_blk_d = first_q;
          res_ok_d  = 1'b1;
          state_d   = S_RESP;
        end else begin
          first_mode_d = 1'b0;
          launch       = 1'b1;
          launch_start = cur_q + 16'd1;
        end
      end

      // Walk the chain and count its length.
      S_WALK: begin
        if (cur_q == cba_pkg::NO_BLOCK || cur_q == 16'd0) begin
          if (cur_q == 16'd0 || len_q != cnt_q) begin
            res_blk_d = cba_pkg::NO_BLOCK;
            res_ok_d  = 1'b0;
            state_d   = S_RESP;
          end else begin
            cur_d   = head_q;
            state_d = S_CLR;
          end
        end else if (len_q == cnt_q) begin
          res_blk_d = cba_pkg::NO_BLOCK;
          res_ok_d  = 1'b0;
          state_d   = S_RESP;
        end else begin
          len_d = len_q + 12'd1;
          if (!cba_pkg::in_table(cur_q)) begin
            cur_d = cba_pkg::NO_BLOCK;
          end else begin
            ram_req_o.addr = cba_pkg::blk_addr(cur_q);
            state_d = S_WWAIT;
          end
        end
      end

      S_WWAIT: begin
        cur_d   = ram_rdata_i;
        state_d = S_WALK;
      end

      // Clear the chain link by link.
      S_CLR: begin
        if (cur_q == cba_pkg::NO_BLOCK || !cba_pkg::in_table(cur_q)) begin
          free_d    = free_q + {4'd0, cnt_q};
          res_blk_d = cba_pkg::NO_BLOCK;
          res_ok_d  = 1'b1;
          state_d   = S_RESP;
        end else begin
          ram_req_o.addr = cba_pkg::blk_addr(cur_q);
          state_d = S_CLRW;
        end
      end

      S_CLRW: begin
        ram_req_o = '{we: 1'b1, addr: cba_pkg::blk_addr(cur_q), wdata: 16'd0};
        cur_d   = ram_rdata_i;
        state_d = S_CLR;
      end

      S_LOOK: begin
        res_blk_d = ram_rdata_i;
        res_ok_d  = 1'b1;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Set up a search: first pass from the start to the limit, then wrap.
    if (launch) begin
      idx_d      = (launch_start < cba_pkg::RSV_BLOCKS) ? cba_pkg::RSV_BLOCKS : launch_start;
      bound_d    = lim;
      wrap_end_d = (launch_start < cba_pkg::TABLE_LIMIT) ? launch_start
                                                         : cba_pkg::TABLE_LIMIT;
      phase_d    = 1'b0;
      rdv_d      = 1'b0;
      state_d    = S_SRCH;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      idx_q   <= cba_pkg::RSV_BLOCKS;
      rdv_q   <= 1'b0;
      fmt_q   <= 1'b0;
      free_q  <= {4'd0, cba_pkg::CARD_RESET} - cba_pkg::RSV_BLOCKS;
      last_q  <= cba_pkg::FIRST_LAST;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rdv_q   <= rdv_d;
      fmt_q   <= fmt_d;
      free_q  <= free_d;
      last_q  <= last_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    bound_q      <= bound_d;
    wrap_end_q   <= wrap_end_d;
    phase_q      <= phase_d;
    rdidx_q      <= rdidx_d;
    first_mode_q <= first_mode_d;
    first_q      <= first_d;
    cur_q        <= cur_d;
    head_q       <= head_d;
    left_q       <= left_d;
    cnt_q        <= cnt_d;
    len_q        <= len_d;
    res_blk_q    <= res_blk_d;
    res_ok_q     <= res_ok_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = '{result_block: res_blk_q, ok: res_ok_q, free_left: free_q};

endmodule

// File: rtl/block_chain_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator
// Linked block table with chain allocate, free, lookup and reformat.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd (kind, block_number, block_count), one result
// beat per command leaves on rsp (result_block, ok, free_left). cfg writes the
// card size; write it only while no command is in flight.
// Timing: every command is paced by the single port of the link memory, one
// access per cycle. Reformat sweeps the whole table; free walks the chain to
// count its links and then clears them link by link; allocate runs one
// next-fit search of the table per block taken, so its time grows with the
// count and the table size.
// One command is worked at a time; the next is taken once the result moves to
// the output register, so a stalled receiver holds at most one finished beat
// plus one waiting in the sequencer.
// Reset: the link memory is cleared by a sweep of every table entry after reset,
// during which cmd.ready stays low; cfg writes are taken at all times.
// ----------------------------------------------------------------------------
module block_chain_allocator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cba_cmd_if.sink   cmd,
  cba_rsp_if.source rsp,
  cba_cfg_if.sink   cfg
);

  logic [11:0]        card_q;
  cba_pkg::ram_req_t  ram_req;
  logic [15:0]        ram_rdata;
  logic               res_valid, res_ready;
  cba_pkg::result_t   res;
  logic               out_valid_q;
  cba_pkg::result_t   out_q;

  // Card size register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_q <= cba_pkg::CARD_RESET;
    end else if (cfg.valid) begin
      card_q <= cfg.data;
    end
  end

  cba_link_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  cba_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .card_blocks_i  (card_q),
    .cmd_valid_i    (cmd.valid),
    .cmd_ready_o    (cmd.ready),
    .kind_i         (cmd.kind),
    .block_number_i (cmd.block_number),
    .block_count_i  (cmd.block_count),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // Output register between sequencer and receiver.
  assign res_ready = !out_valid_q || rsp.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.result_block = out_q.result_block;
  assign rsp.ok           = out_q.ok;
  assign rsp.free_left    = out_q.free_left;

  // A failed beat never names a block.
  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ok) |-> (rsp.result_block == cba_pkg::NO_BLOCK))
    else $error("failed result carries a block number");

  // One command at a time: an accepted command drops ready.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command taken while busy");

  // A result handed over shows up on the output.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> rsp.valid)
    else $error("result lost in the output register");

endmodule
